FILE: sv/kmp_pkg.sv
// Shared types, codes and default sizes for the KMP stream matcher.
`timescale 1ns / 1ps

package kmp_pkg;

    localparam int DEF_MAX_PATTERN = 1024;
    localparam int DEF_SYMBOL_BITS = 16;
    localparam int SYMBOL_W        = 16;
    localparam int CFG_W           = 11;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_NEW    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_EARLY = 2'd2;

    typedef struct packed {
        logic [1:0]          operation;
        logic [SYMBOL_W-1:0] symbol;
    } in_t;

    typedef struct packed {
        logic       match;
        logic       found;
        logic [1:0] status;
    } out_t;

endpackage

FILE: sv/kmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module kmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/kmp_out_stage.sv
// Output register that holds one result until the consumer takes it.
`timescale 1ns / 1ps

module kmp_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  kmp_pkg::out_t res,
    output logic          res_free,
    output logic          out_valid,
    input  logic          out_ready,
    output kmp_pkg::out_t out_res
);
    import kmp_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    out_t out_res_reg;
    logic load;

    assign res_free       = !out_valid_reg || out_ready;
    assign load           = res_valid && res_free;
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: sv/kmp_engine.sv
// Sequencer that builds the failure table and walks failure links over the two memories.
`timescale 1ns / 1ps

module kmp_engine #(
    parameter int MAX_PATTERN = kmp_pkg::DEF_MAX_PATTERN,
    parameter int SYMBOL_BITS = kmp_pkg::DEF_SYMBOL_BITS,
    localparam int IDX_W = $clog2(MAX_PATTERN),
    localparam int CNT_W = $clog2(MAX_PATTERN + 1),
    localparam int LEN_W = (CNT_W > kmp_pkg::CFG_W) ? CNT_W : kmp_pkg::CFG_W,
    localparam int SYM_W = (SYMBOL_BITS < kmp_pkg::SYMBOL_W) ? SYMBOL_BITS : kmp_pkg::SYMBOL_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  kmp_pkg::in_t     in_req,
    input  logic [LEN_W-1:0] eff_len,
    input  logic             cfg_we,
    output logic             res_valid,
    output kmp_pkg::out_t    res,
    input  logic             res_free,
    output logic             pat_we,
    output logic [IDX_W-1:0] pat_waddr,
    output logic [SYM_W-1:0] pat_wdata,
    output logic [IDX_W-1:0] pat_raddr,
    input  logic [SYM_W-1:0] pat_rdata,
    output logic             fail_we,
    output logic [IDX_W-1:0] fail_waddr,
    output logic [IDX_W-1:0] fail_wdata,
    output logic [IDX_W-1:0] fail_raddr,
    input  logic [IDX_W-1:0] fail_rdata
);
    import kmp_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] build_pos_reg, build_pos_next;
    logic [IDX_W-1:0] match_pos_reg, match_pos_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             text_reg, text_next;
    out_t             res_reg, res_next;

    logic             accept;
    logic [SYM_W-1:0] sym_in;
    logic             pat_full;
    logic [IDX_W-1:0] text_start;
    logic [IDX_W-1:0] start_pos;
    logic             eq;
    logic             step_back;
    logic [CNT_W-1:0] new_pos;
    logic             hit;
    logic [LEN_W-1:0] len_m1_full;
    logic [IDX_W-1:0] len_m1;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign sym_in      = in_req.symbol[SYM_W-1:0];
    assign pat_full    = LEN_W'(count_reg) >= eff_len;
    assign text_start  = (LEN_W'(match_pos_reg) >= eff_len) ? '0 : match_pos_reg;
    assign eq          = (pat_rdata == sym_reg);
    assign step_back   = (pos_reg != '0) && !eq;
    assign new_pos     = CNT_W'(pos_reg) + CNT_W'(eq);
    assign hit         = (LEN_W'(new_pos) == eff_len);
    assign len_m1_full = eff_len - LEN_W'(1);
    assign len_m1      = len_m1_full[IDX_W-1:0];

    always_comb
    begin
        case (state_reg)
            S_IDLE:  start_pos = (in_req.operation == OP_TEXT) ? text_start : build_pos_reg;
            S_CMP:   start_pos = fail_rdata;
            default: start_pos = pos_reg;
        endcase
    end

    assign pat_raddr  = start_pos;
    assign fail_raddr = (state_reg == S_CMP && !step_back) ? len_m1 : start_pos - IDX_W'(1);

    assign pat_we     = accept && (in_req.operation == OP_APPEND) && !pat_full;
    assign pat_waddr  = count_reg[IDX_W-1:0];
    assign pat_wdata  = sym_in;

    assign fail_we    = (pat_we && count_reg == '0)
                     || (state_reg == S_CMP && !step_back && !text_reg);
    assign fail_waddr = count_reg[IDX_W-1:0];
    assign fail_wdata = (state_reg == S_IDLE) ? '0 : new_pos[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        build_pos_next = build_pos_reg;
        match_pos_next = match_pos_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        sym_next       = sym_reg;
        text_next      = text_reg;
        res_next       = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sym_next        = sym_in;
                    res_next.match  = 1'b0;
                    res_next.found  = found_reg;
                    res_next.status = ST_OK;
                    state_next      = S_DONE;
                    case (in_req.operation)
                        OP_CLEAR:
                        begin
                            count_next     = '0;
                            build_pos_next = '0;
                            match_pos_next = '0;
                            found_next     = 1'b0;
                            res_next.found = 1'b0;
                        end
                        OP_APPEND:
                        begin
                            if (pat_full)
                            begin
                                res_next.status = ST_DROP;
                            end
                            else if (count_reg == '0)
                            begin
                                count_next     = CNT_W'(1);
                                build_pos_next = '0;
                            end
                            else
                            begin
                                pos_next   = build_pos_reg;
                                text_next  = 1'b0;
                                state_next = S_CMP;
                            end
                        end
                        OP_TEXT:
                        begin
                            if (!pat_full)
                            begin
                                res_next.status = ST_EARLY;
                            end
                            else
                            begin
                                pos_next   = text_start;
                                text_next  = 1'b1;
                                state_next = S_CMP;
                            end
                        end
                        default:
                        begin
                            match_pos_next = '0;
                            found_next     = 1'b0;
                            res_next.found = 1'b0;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                if (step_back)
                begin
                    pos_next = fail_rdata;
                end
                else if (!text_reg)
                begin
                    build_pos_next = new_pos[IDX_W-1:0];
                    count_next     = count_reg + CNT_W'(1);
                    state_next     = S_DONE;
                end
                else if (hit)
                begin
                    found_next     = 1'b1;
                    res_next.match = 1'b1;
                    res_next.found = 1'b1;
                    state_next     = S_TAIL;
                end
                else
                begin
                    match_pos_next = new_pos[IDX_W-1:0];
                    state_next     = S_DONE;
                end
            end
            S_TAIL:
            begin
                match_pos_next = fail_rdata;
                state_next     = S_DONE;
            end
            default:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase

        if (cfg_we)
        begin
            match_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            build_pos_reg <= '0;
            match_pos_reg <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            build_pos_reg <= build_pos_next;
            match_pos_reg <= match_pos_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        sym_reg  <= sym_next;
        text_reg <= text_next;
        res_reg  <= res_next;
    end

    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

endmodule

FILE: sv/kmp_stream_matcher_core.sv
// Top level of the KMP stream matcher: length register, memories, sequencer, output register.
`timescale 1ns / 1ps

// Knuth-Morris-Pratt matcher over streamed symbols. Load the pattern one symbol per request
// (operation 1); its failure table is built as each symbol arrives. Stream text symbols
// (operation 2); each request returns one result with match, the sticky found flag and a
// status. Operation 0 empties the pattern, operation 3 starts a new text. Every request
// returns exactly one result. Clear, new-text, dropped and early requests, and the first
// pattern symbol, go straight to the result state. Other pattern symbols and text
// symbols pass through the compare state, which follows one failure link per step, and a
// text symbol that completes a match also passes through the tail state; each link
// step is one read of the pattern memory and the failure memory, both with a registered
// read. A request is taken while the previous result still waits in the output register.
// Write pattern_length only while idle; the write also rewinds the current scan position.
module kmp_stream_matcher_core #(
    parameter int MAX_PATTERN = kmp_pkg::DEF_MAX_PATTERN,
    parameter int SYMBOL_BITS = kmp_pkg::DEF_SYMBOL_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  kmp_pkg::in_t               in_req,
    output logic                       out_valid,
    input  logic                       out_ready,
    output kmp_pkg::out_t              out_res,
    input  logic                       cfg_we,
    input  logic [kmp_pkg::CFG_W-1:0]  cfg_wdata
);
    import kmp_pkg::*;

    localparam int IDX_W = $clog2(MAX_PATTERN);
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int SYM_W = (SYMBOL_BITS < SYMBOL_W) ? SYMBOL_BITS : SYMBOL_W;

    logic [CFG_W-1:0] pattern_length_reg;
    logic [CFG_W-1:0] pattern_length_next;
    logic [LEN_W-1:0] len_ext;
    logic [LEN_W-1:0] eff_len;

    logic             res_valid;
    out_t             res;
    logic             res_free;

    logic             pat_we;
    logic [IDX_W-1:0] pat_waddr;
    logic [SYM_W-1:0] pat_wdata;
    logic [IDX_W-1:0] pat_raddr;
    logic [SYM_W-1:0] pat_rdata;
    logic             fail_we;
    logic [IDX_W-1:0] fail_waddr;
    logic [IDX_W-1:0] fail_wdata;
    logic [IDX_W-1:0] fail_raddr;
    logic [IDX_W-1:0] fail_rdata;

    assign pattern_length_next = cfg_we ? cfg_wdata : pattern_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= CFG_W'(1);
        end
        else
        begin
            pattern_length_reg <= pattern_length_next;
        end
    end

    assign len_ext = LEN_W'(pattern_length_reg);

    always_comb
    begin
        if (len_ext == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (len_ext > LEN_W'(MAX_PATTERN))
        begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = len_ext;
        end
    end

    kmp_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_PATTERN)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (pat_waddr),
        .wdata (pat_wdata),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    kmp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_PATTERN)
    ) u_failure_ram (
        .clk   (clk),
        .we    (fail_we),
        .waddr (fail_waddr),
        .wdata (fail_wdata),
        .raddr (fail_raddr),
        .rdata (fail_rdata)
    );

    kmp_engine #(
        .MAX_PATTERN (MAX_PATTERN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_req     (in_req),
        .eff_len    (eff_len),
        .cfg_we     (cfg_we),
        .res_valid  (res_valid),
        .res        (res),
        .res_free   (res_free),
        .pat_we     (pat_we),
        .pat_waddr  (pat_waddr),
        .pat_wdata  (pat_wdata),
        .pat_raddr  (pat_raddr),
        .pat_rdata  (pat_rdata),
        .fail_we    (fail_we),
        .fail_waddr (fail_waddr),
        .fail_wdata (fail_wdata),
        .fail_raddr (fail_raddr),
        .fail_rdata (fail_rdata)
    );

    kmp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_free  (res_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

endmodule

FILE: sv/kmp_checker.sv
// Port-level checks for the KMP stream matcher and their binding to the top level.
`timescale 1ns / 1ps

module kmp_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic          out_valid,
    input  logic          out_ready,
    input  kmp_pkg::out_t out_res
);
    import kmp_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       in_fire;
    logic       out_fire;

    assign in_fire      = in_valid && in_ready;
    assign out_fire     = out_valid && out_ready;
    assign pending_next = pending_reg + 2'(in_fire) - 2'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_res))
        else $error("result changed or dropped while stalled");

    a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.match |-> out_res.found && (out_res.status == ST_OK))
        else $error("match without found flag or with error status");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> pending_reg != 2'd0)
        else $error("result delivered with no request outstanding");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !in_ready)
        else $error("request taken while engine and output register are both full");

endmodule

bind kmp_stream_matcher_core kmp_checker u_kmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
);

FILE: tb/testbench.sv
// Self-checking testbench for kmp_stream_matcher_core against an in-bench KMP predictor.
`timescale 1ns / 1ps

module testbench;
    import kmp_pkg::*;

    localparam int MAX_LEN      = DEF_MAX_PATTERN;
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 280;
    localparam int LONG_LEN     = 160;
    localparam int DRAIN_CYCLES = 20;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_t                 in_req;
    logic                out_valid;
    logic                out_ready;
    out_t                out_res;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;

    logic [SYMBOL_W-1:0] pat_mem [MAX_LEN];
    logic [CFG_W-1:0]    link_mem [MAX_LEN];
    int unsigned         pat_cnt;
    int unsigned         build_pos;
    int unsigned         scan_pos;
    logic                found_q;
    logic [CFG_W-1:0]    len_reg;

    out_t                outcome_q [$];
    int unsigned         sent = 0;
    int unsigned         checked = 0;
    int unsigned         errors = 0;
    int unsigned         idle_cycles = 0;
    bit                  calm = 1'b0;

    kmp_stream_matcher_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_len();
        if (len_reg == 0)
            return 1;
        if (len_reg > MAX_LEN)
            return MAX_LEN;
        return len_reg;
    endfunction

    function automatic void clear_matcher_state();
        int unsigned i;
        for (i = 0; i < MAX_LEN; i++)
        begin
            pat_mem[i]  = '0;
            link_mem[i] = '0;
        end
        pat_cnt   = 0;
        build_pos = 0;
        scan_pos  = 0;
        found_q   = 1'b0;
        len_reg   = 1;
    endfunction

    function automatic int unsigned follow_links(int unsigned pos, logic [SYMBOL_W-1:0] sym);
        while (pos > 0 && pos < MAX_LEN && pat_mem[pos] != sym)
            pos = link_mem[pos - 1];
        if (pos < MAX_LEN && pat_mem[pos] == sym)
            pos++;
        return pos;
    endfunction

    function automatic out_t match_outcome(in_t req);
        out_t        r;
        int unsigned len;
        int unsigned j;
        r   = '0;
        len = eff_len();
        case (req.operation)
            OP_CLEAR:
            begin
                pat_cnt   = 0;
                build_pos = 0;
                scan_pos  = 0;
                found_q   = 1'b0;
            end
            OP_APPEND:
            begin
                if (pat_cnt >= len)
                    r.status = ST_DROP;
                else
                begin
                    pat_mem[pat_cnt] = req.symbol;
                    if (pat_cnt == 0)
                    begin
                        link_mem[0] = '0;
                        build_pos   = 0;
                    end
                    else
                    begin
                        build_pos = follow_links(build_pos, req.symbol);
                        link_mem[pat_cnt] = CFG_W'(build_pos);
                    end
                    pat_cnt++;
                end
            end
            OP_TEXT:
            begin
                if (pat_cnt < len)
                    r.status = ST_EARLY;
                else
                begin
                    j = scan_pos;
                    if (j >= len)
                        j = 0;
                    j = follow_links(j, req.symbol);
                    if (j >= len)
                    begin
                        r.match = 1'b1;
                        found_q = 1'b1;
                        j = link_mem[len - 1];
                    end
                    scan_pos = j;
                end
            end
            default:
            begin
                scan_pos = 0;
                found_q  = 1'b0;
            end
        endcase
        r.found = found_q;
        return r;
    endfunction

    task automatic send_req(input logic [1:0] op, input logic [SYMBOL_W-1:0] sym);
        int unsigned gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= '{operation: op, symbol: sym};
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        outcome_q.insert(outcome_q.size(), match_outcome(in_req));
        sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        len_reg  = value;
        scan_pos = 0;
    endtask

    task automatic test_default_length();
        send_req(OP_TEXT, 16'hFFFF);
        send_req(OP_APPEND, 16'hFFFF);
        send_req(OP_APPEND, 16'h0000);
        send_req(OP_TEXT, 16'hFFFF);
        send_req(OP_TEXT, 16'h0000);
        send_req(OP_NEW, 16'hA5A5);
        send_req(OP_TEXT, 16'h0000);
        send_req(OP_CLEAR, 16'h5A5A);
        send_req(OP_TEXT, 16'hFFFF);
    endtask

    task automatic test_overlapping_matches();
        write_length(11'd3);
        send_req(OP_APPEND, 16'h0000);
        send_req(OP_APPEND, 16'hFFFF);
        send_req(OP_APPEND, 16'h0000);
        send_req(OP_TEXT, 16'h0000);
        send_req(OP_TEXT, 16'hFFFF);
        send_req(OP_TEXT, 16'h0000);
        send_req(OP_TEXT, 16'hFFFF);
        send_req(OP_TEXT, 16'h0000);
    endtask

    task automatic test_length_rewrite();
        write_length(11'd2);
        send_req(OP_TEXT, 16'h0000);
        send_req(OP_TEXT, 16'hFFFF);
        write_length(11'd4);
        send_req(OP_TEXT, 16'h0000);
        send_req(OP_APPEND, 16'hFFFF);
        send_req(OP_TEXT, 16'hFFFF);
        write_length(11'd0);
        send_req(OP_TEXT, 16'h0000);
        send_req(OP_APPEND, 16'h1234);
    endtask

    task automatic test_long_pattern();
        logic [SYMBOL_W-1:0] a;
        logic [SYMBOL_W-1:0] b;
        int unsigned         i;
        a    = 16'($urandom);
        b    = ~a;
        calm = 1'b1;
        write_length(11'h7FF);
        send_req(OP_CLEAR, a);
        send_req(OP_APPEND, a);
        send_req(OP_APPEND, b);
        send_req(OP_TEXT, a);
        write_length(CFG_W'(LONG_LEN));
        send_req(OP_CLEAR, a);
        for (i = 0; i < LONG_LEN - 1; i++)
            send_req(OP_APPEND, a);
        send_req(OP_APPEND, b);
        send_req(OP_APPEND, a);
        send_req(OP_NEW, b);
        for (i = 0; i < LONG_LEN + 4; i++)
            send_req(OP_TEXT, a);
        send_req(OP_TEXT, b);
        send_req(OP_TEXT, b);
        calm = 1'b0;
        write_length(CFG_W'(LONG_LEN / 2));
        send_req(OP_TEXT, a);
        send_req(OP_TEXT, b);
        write_length(11'd5);
        for (i = 0; i < 7; i++)
            send_req(OP_TEXT, a);
        send_req(OP_TEXT, b);
    endtask

    task automatic test_random_streams();
        logic [SYMBOL_W-1:0] alpha [3];
        int unsigned         goal;
        int unsigned         phase;
        int unsigned         len;
        int unsigned         n;
        int unsigned         pick;
        int unsigned         alpha_n;
        int unsigned         i;
        int unsigned         k;
        goal  = sent + RANDOM_ITEMS;
        phase = 0;
        while (sent < goal)
        begin
            phase++;
            calm = (phase % 6 == 3);
            pick = $urandom_range(0, 99);
            if (pick < 5)
                len = 0;
            else if (pick < 70)
                len = $urandom_range(1, 6);
            else if (pick < 90)
                len = $urandom_range(7, 16);
            else
                len = $urandom_range(17, 48);
            write_length(CFG_W'(len));
            if (phase == 1 || $urandom_range(0, 3) != 0)
                send_req(OP_CLEAR, 16'($urandom));
            alpha_n = $urandom_range(1, 3);
            for (i = 0; i < 3; i++)
                alpha[i] = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
                send_req(OP_TEXT, alpha[0]);
            while (pat_cnt < eff_len())
                send_req(OP_APPEND, alpha[$urandom_range(0, alpha_n - 1)]);
            if ($urandom_range(0, 2) == 0)
                send_req(OP_APPEND, 16'($urandom));
            send_req(OP_NEW, 16'($urandom));
            n = $urandom_range(10, 40);
            for (i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_req(2'($urandom_range(0, 3)), 16'($urandom));
                else if (pick < 25 && pat_cnt >= eff_len())
                begin
                    for (k = 0; k < eff_len(); k++)
                        send_req(OP_TEXT, pat_mem[k]);
                end
                else if (pick < 28)
                    wait_drained();
                else
                    send_req(OP_TEXT, alpha[$urandom_range(0, alpha_n - 1)]);
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        out_t exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                checked++;
                if (outcome_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: none outstanding, got m%0b f%0b s%0d",
                                 checked, out_res.match, out_res.found, out_res.status);
                end
                else
                begin
                    exp = outcome_q.pop_front();
                    if (out_res.match !== exp.match || out_res.found !== exp.found ||
                        out_res.status !== exp.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("result %0d: expected m%0b f%0b s%0d, got m%0b f%0b s%0d",
                                     checked, exp.match, exp.found, exp.status,
                                     out_res.match, out_res.found, out_res.status);
                    end
                end
            end
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("kmp_stream_matcher_core verification failed");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_req    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        clear_matcher_state();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_default_length();
        test_overlapping_matches();
        test_length_rewrite();
        test_long_pattern();
        test_random_streams();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
            $display("kmp_stream_matcher_core verification clean");
        else
            $display("kmp_stream_matcher_core verification failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/kmp_pkg.sv
sv/kmp_ram.sv
sv/kmp_out_stage.sv
sv/kmp_engine.sv
sv/kmp_stream_matcher_core.sv
sv/kmp_checker.sv
tb/testbench.sv
